// ----- src/rc_frame_decode_stick_polar_defines.svh -----
// Assertion macros used by the frame decoder top level.
`ifndef RC_FRAME_DECODE_STICK_POLAR_DEFINES_SVH
`define RC_FRAME_DECODE_STICK_POLAR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RCFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rcfd_pkg.sv -----
// Constants and helper functions of the remote-control frame decoder.
package rcfd_pkg;

  localparam int unsigned STORE_DEPTH = 15;
  localparam int unsigned STORE_AW    = 4;
  localparam int unsigned CH_W        = 11;
  localparam int unsigned NUM_W       = 18;
  localparam int unsigned CORDIC_N    = 16;
  localparam int unsigned XY_W        = 35;
  localparam int unsigned Z_W         = 25;
  localparam int unsigned ANG_W       = 22;

  localparam logic [ANG_W-1:0] DEG45_Q = 22'd2949120;
  localparam logic [22:0]      DEG90_Q = 23'd5898240;
  localparam logic [24:0]      DEG180_Q = 25'd11796480;
  localparam logic [24:0]      DEG360_Q = 25'd23592960;

  localparam logic [6:0]  PCT_SCALE = 7'd100;
  localparam logic [15:0] PUSH_MAX  = 16'hFFFF;

  // Register indexes of the configuration port.
  localparam logic REG_CENTER     = 1'b0;
  localparam logic REG_FULL_SCALE = 1'b1;

  localparam logic [CH_W-1:0] CENTER_RST     = 11'd1024;
  localparam logic [CH_W-1:0] FULL_SCALE_RST = 11'd660;

  // atan(2^-i) in Q16 degrees.
  function automatic logic [ANG_W-1:0] atan_q16(input logic [3:0] i);
    logic [ANG_W-1:0] r;
    case (i)
      4'd0:    r = 22'd2949120;
      4'd1:    r = 22'd1740967;
      4'd2:    r = 22'd919879;
      4'd3:    r = 22'd466945;
      4'd4:    r = 22'd234379;
      4'd5:    r = 22'd117304;
      4'd6:    r = 22'd58666;
      4'd7:    r = 22'd29335;
      4'd8:    r = 22'd14668;
      4'd9:    r = 22'd7334;
      4'd10:   r = 22'd3667;
      4'd11:   r = 22'd1833;
      4'd12:   r = 22'd917;
      4'd13:   r = 22'd458;
      4'd14:   r = 22'd229;
      4'd15:   r = 22'd115;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/rcfd_if.sv -----
// Handshake interfaces for the frame byte input and the decoded result output.
interface rcfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;
  modport source(output valid, data_byte, frame_start, input ready);
  modport sink(input valid, data_byte, frame_start, output ready);
endinterface

interface rcfd_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        left_push_percent;
  logic [8:0]         left_angle_deg;
  logic [15:0]        right_push_percent;
  logic [8:0]         right_angle_deg;
  logic [7:0]         switch_code;
  logic signed [15:0] mouse_x;
  logic signed [15:0] mouse_y;
  logic signed [15:0] mouse_z;
  logic [7:0]         mouse_left;
  logic [7:0]         mouse_right;
  logic [7:0]         key_bits;
  modport source(output valid, left_push_percent, left_angle_deg, right_push_percent,
                 right_angle_deg, switch_code, mouse_x, mouse_y, mouse_z,
                 mouse_left, mouse_right, key_bits, input ready);
  modport sink(input valid, left_push_percent, left_angle_deg, right_push_percent,
               right_angle_deg, switch_code, mouse_x, mouse_y, mouse_z,
               mouse_left, mouse_right, key_bits, output ready);
endinterface

// ----- src/rc_frame_decode_stick_polar.sv -----
// Remote-control frame decoder top level with stick polar conversion.
// Frame bytes enter on in_i, one item per byte; frame_start marks byte 0, and
// without it the byte is taken at the next position. Bytes 0 to 14 are held
// in a small register file; later bytes are only counted. On the last byte
// of a frame the four stick channels go to two polar units that run side by
// side: a bit-serial divider gives the push percent and a CORDIC with one
// rotation per cycle gives the angle. The divider finishes last and so sets
// when the result is registered in the output register and shown on out_o.
// Bytes after the end of a frame are dropped until the next frame_start.
// The result sits in an output register until taken; bytes keep flowing
// meanwhile, and only the last byte of the next frame waits for it.
// in_i.ready is low while the polar units work.
// Reset clears the byte position (next byte counts as byte 0), sets
// stick_center to 1024 and stick_full_scale to 660, and empties the output.
// Registers on the APB port: stick_center at 0x0, stick_full_scale at 0x4.
`include "rc_frame_decode_stick_polar_defines.svh"

module rc_frame_decode_stick_polar #(
  parameter int unsigned FRAME_BYTES = 18
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rcfd_in_if.sink      in_i,
  rcfd_out_if.source   out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam int unsigned PW   = $clog2(FRAME_BYTES + 1);
  localparam int unsigned CW   = rcfd_pkg::CH_W;
  localparam logic [PW-1:0] LAST = PW'(FRAME_BYTES - 1);
  localparam logic [PW-1:0] DONE = PW'(FRAME_BYTES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic          state_q, state_d;
  logic [PW-1:0] pos_q, pos_d, pos_eff;
  logic [7:0]    store_q [rcfd_pkg::STORE_DEPTH];
  logic [CW-1:0] center_q, full_scale_q;
  logic          out_valid_q;
  logic          in_acc, start, last_byte, cfg_wr;
  logic          l_done, r_done;
  logic [15:0]   l_push, r_push;
  logic [8:0]    l_deg, r_deg;
  logic [CW-1:0] ch0, ch1, ch2, ch3;
  logic [1:0]    s1, s2;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == rcfd_pkg::REG_FULL_SCALE) ? {21'd0, full_scale_q}
                                                         : {21'd0, center_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q     <= rcfd_pkg::CENTER_RST;
      full_scale_q <= rcfd_pkg::FULL_SCALE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == rcfd_pkg::REG_FULL_SCALE) begin
        full_scale_q <= pwdata[CW-1:0];
      end else begin
        center_q <= pwdata[CW-1:0];
      end
    end
  end

  // Byte intake. The final byte waits while an older result is still held.
  assign in_i.ready = (state_q == ST_IDLE) && !(out_valid_q && (pos_q == LAST));
  assign in_acc     = in_i.valid && in_i.ready;
  assign pos_eff    = in_i.frame_start ? '0 : pos_q;
  assign last_byte  = pos_eff == LAST;
  assign start      = in_acc && last_byte;

  always_comb begin
    pos_d   = pos_q;
    state_d = state_q;
    if (in_acc && (pos_eff < DONE)) begin
      pos_d = last_byte ? DONE : PW'(pos_eff + 1'b1);
    end
    case (state_q)
      ST_IDLE: if (start) state_d = ST_BUSY;
      ST_BUSY: if (l_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (pos_eff < PW'(rcfd_pkg::STORE_DEPTH))) begin
      store_q[pos_eff[rcfd_pkg::STORE_AW-1:0]] <= in_i.data_byte;
    end
  end

  // Channel unpacking from the stored bytes.
  assign ch0 = {store_q[1][2:0], store_q[0]};
  assign ch1 = {store_q[2][5:0], store_q[1][7:3]};
  assign ch2 = {store_q[4][0], store_q[3], store_q[2][7:6]};
  assign ch3 = {store_q[5][3:0], store_q[4][7:1]};
  assign s1  = store_q[5][7:6];
  assign s2  = store_q[5][5:4];

  rcfd_polar u_left (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cx_i        (ch2),
    .cy_i        (ch3),
    .center_i    (center_q),
    .full_scale_i(full_scale_q),
    .done_o      (l_done),
    .push_o      (l_push),
    .deg_o       (l_deg)
  );

  rcfd_polar u_right (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cx_i        (ch0),
    .cy_i        (ch1),
    .center_i    (center_q),
    .full_scale_i(full_scale_q),
    .done_o      (r_done),
    .push_o      (r_push),
    .deg_o       (r_deg)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_BUSY && l_done) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_BUSY && l_done) begin
      out_o.left_push_percent  <= l_push;
      out_o.left_angle_deg     <= l_deg;
      out_o.right_push_percent <= r_push;
      out_o.right_angle_deg    <= r_deg;
      out_o.switch_code        <= (8'h10 << s1) | (8'h01 << s2);
      out_o.mouse_x            <= $signed({store_q[7], store_q[6]});
      out_o.mouse_y            <= $signed({store_q[9], store_q[8]});
      out_o.mouse_z            <= $signed({store_q[11], store_q[10]});
      out_o.mouse_left         <= store_q[12];
      out_o.mouse_right        <= store_q[13];
      out_o.key_bits           <= store_q[14];
    end
  end

  assign out_o.valid = out_valid_q;

  `RCFD_ASSERT_NOW(a_busy_blocks_in, clk_i, rst_ni, state_q == ST_BUSY, !in_i.ready,
    "byte accepted while the polar units are busy")
  `RCFD_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start, state_q == ST_BUSY,
    "last byte did not start the polar units")
  `RCFD_ASSERT_NOW(a_pos_range, clk_i, rst_ni, 1'b1, pos_q <= DONE,
    "byte position beyond the frame end")
  `RCFD_ASSERT_NOW(a_units_in_step, clk_i, rst_ni, 1'b1, l_done == r_done,
    "left and right polar units out of step")
  `RCFD_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, start, !out_valid_q,
    "new frame finished while a result is still held")
endmodule

// ----- src/rcfd_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
module rcfd_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [rcfd_pkg::NUM_W-1:0]       num_i,
  input  logic [rcfd_pkg::CH_W-1:0]        den_i,
  output logic                             busy_o,
  output logic [rcfd_pkg::NUM_W-1:0]       quot_o
);
  localparam int unsigned NW = rcfd_pkg::NUM_W;
  localparam int unsigned DW = rcfd_pkg::CH_W;

  logic          busy_q, busy_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] nq_q, nq_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   trial;
  logic          ge;

  always_comb begin
    trial  = {rem_q, nq_q[NW-1]};
    ge     = trial >= {1'b0, den_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    nq_d   = nq_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      nq_d   = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      nq_d  = {nq_q[NW-2:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(NW - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = nq_q;
endmodule

// ----- src/rcfd_cordic.sv -----
// Vectoring CORDIC, one rotation per cycle, angle of (a,b) in the first octant.
module rcfd_cordic (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rcfd_pkg::CH_W-1:0]      a_i,
  input  logic [rcfd_pkg::CH_W-1:0]      b_i,
  output logic                           busy_o,
  output logic [rcfd_pkg::ANG_W-1:0]     angle_o
);
  localparam int unsigned XW = rcfd_pkg::XY_W;
  localparam int unsigned ZW = rcfd_pkg::Z_W;

  logic                 busy_q, busy_d;
  logic [3:0]           it_q, it_d;
  logic signed [XW-1:0] x_q, x_d, y_q, y_d, sx, sy;
  logic signed [ZW-1:0] z_q, z_d, at;

  // Arithmetic shift that truncates toward zero.
  function automatic logic signed [XW-1:0] shr_tz(input logic signed [XW-1:0] v,
                                                  input logic [3:0] k);
    logic [XW-1:0] mag;
    mag = v[XW-1] ? XW'(-v) : v;
    mag = mag >> k;
    return v[XW-1] ? $signed(XW'(-mag)) : $signed(mag);
  endfunction

  always_comb begin
    sx     = shr_tz(x_q, it_q);
    sy     = shr_tz(y_q, it_q);
    at     = $signed({3'b000, rcfd_pkg::atan_q16(it_q)});
    busy_d = busy_q;
    it_d   = it_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (start_i) begin
      it_d = '0;
      x_d  = $signed({4'b0000, a_i, 20'd0});
      y_d  = $signed({4'b0000, b_i, 20'd0});
      if (b_i == '0) begin
        z_d = '0;
      end else if (b_i == a_i) begin
        z_d = $signed({3'b000, rcfd_pkg::DEG45_Q});
      end else begin
        z_d    = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (!y_q[XW-1]) begin
        x_d = x_q + sy;
        y_d = y_q - sx;
        z_d = z_q + at;
      end else begin
        x_d = x_q - sy;
        y_d = y_q + sx;
        z_d = z_q - at;
      end
      it_d = it_q + 4'd1;
      if (it_q == 4'(rcfd_pkg::CORDIC_N - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      it_q   <= '0;
    end else begin
      busy_q <= busy_d;
      it_q   <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  always_comb begin
    if (z_q[ZW-1]) begin
      angle_o = '0;
    end else if (z_q > $signed({3'b000, rcfd_pkg::DEG45_Q})) begin
      angle_o = rcfd_pkg::DEG45_Q;
    end else begin
      angle_o = z_q[rcfd_pkg::ANG_W-1:0];
    end
  end

  assign busy_o = busy_q;
endmodule

// ----- src/rcfd_polar.sv -----
// Polar conversion of one stick: push percent through the divider, angle through CORDIC.
module rcfd_polar (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rcfd_pkg::CH_W-1:0]   cx_i,
  input  logic [rcfd_pkg::CH_W-1:0]   cy_i,
  input  logic [rcfd_pkg::CH_W-1:0]   center_i,
  input  logic [rcfd_pkg::CH_W-1:0]   full_scale_i,
  output logic                        done_o,
  output logic [15:0]                 push_o,
  output logic [8:0]                  deg_o
);
  localparam int unsigned CW = rcfd_pkg::CH_W;

  logic signed [CW:0]           dx, dy;
  logic [CW-1:0]                adx, ady, a, b;
  logic                         swap;
  logic                         run_q;
  logic                         u_neg_q, v_neg_q, swap_q, zero_q, fs_zero_q;
  logic                         div_busy, cor_busy;
  logic [rcfd_pkg::NUM_W-1:0]   quot;
  logic [rcfd_pkg::ANG_W-1:0]   oct;
  logic [22:0]                  q;
  logic [24:0]                  t;

  always_comb begin
    dx   = $signed({1'b0, cx_i}) - $signed({1'b0, center_i});
    dy   = $signed({1'b0, cy_i}) - $signed({1'b0, center_i});
    adx  = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    ady  = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    // The angle is measured from +y, so x takes the role of the second axis.
    swap = adx > ady;
    a    = swap ? adx : ady;
    b    = swap ? ady : adx;
  end

  rcfd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .num_i  (rcfd_pkg::NUM_W'(a * rcfd_pkg::PCT_SCALE)),
    .den_i  (full_scale_i),
    .busy_o (div_busy),
    .quot_o (quot)
  );

  rcfd_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .a_i    (a),
    .b_i    (b),
    .busy_o (cor_busy),
    .angle_o(oct)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (start_i) begin
      run_q <= 1'b1;
    end else if (done_o) begin
      run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      u_neg_q   <= dy[CW];
      v_neg_q   <= !dx[CW] && (dx != '0);
      swap_q    <= swap;
      zero_q    <= (a == '0);
      fs_zero_q <= (full_scale_i == '0);
    end
  end

  assign done_o = run_q && !div_busy && !cor_busy;

  always_comb begin
    if (fs_zero_q) begin
      push_o = zero_q ? 16'd0 : rcfd_pkg::PUSH_MAX;
    end else if (|quot[rcfd_pkg::NUM_W-1:16]) begin
      push_o = rcfd_pkg::PUSH_MAX;
    end else begin
      push_o = quot[15:0];
    end
    q = swap_q ? 23'(rcfd_pkg::DEG90_Q - {1'b0, oct}) : {1'b0, oct};
    if (!u_neg_q && !v_neg_q) begin
      t = {2'b00, q};
    end else if (u_neg_q && !v_neg_q) begin
      t = 25'(rcfd_pkg::DEG180_Q - {2'b00, q});
    end else if (u_neg_q) begin
      t = 25'(rcfd_pkg::DEG180_Q + {2'b00, q});
    end else begin
      t = 25'(rcfd_pkg::DEG360_Q - {2'b00, q});
    end
    if (zero_q || (t[24:16] == 9'd360)) begin
      deg_o = '0;
    end else begin
      deg_o = t[24:16];
    end
  end
endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the remote-control frame decoder with stick polar conversion.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_LEN = 18;
  localparam longint DEGQ = 65536;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } rx_byte_t;

  typedef struct packed {
    logic [15:0] left_push;
    logic [8:0]  left_deg;
    logic [15:0] right_push;
    logic [8:0]  right_deg;
    logic [7:0]  switch_code;
    logic [15:0] mouse_x;
    logic [15:0] mouse_y;
    logic [15:0] mouse_z;
    logic [7:0]  mouse_left;
    logic [7:0]  mouse_right;
    logic [7:0]  key_bits;
  } decoded_frame_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  rcfd_in_if  rx_if ();
  rcfd_out_if dec_if ();

  rc_frame_decode_stick_polar dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (rx_if),
    .out_o   (dec_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  rx_byte_t       byte_q[$];
  decoded_frame_t frame_exp_q[$];

  // Mirror of the block's state and registers.
  logic [10:0] center_reg, full_scale_reg;
  int unsigned rx_pos;
  logic [7:0]  rx_store[rcfd_pkg::STORE_DEPTH];

  int errors = 0;
  int bytes_sent = 0;
  int frames_seen = 0;
  bit tx_no_gaps = 0;
  bit rx_no_stalls = 0;
  bit long_hold_req = 0;

  longint atan_tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                           29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  function automatic longint shr_trunc(longint v, int k);
    if (v < 0) return -((-v) >>> k);
    return v >>> k;
  endfunction

  // Angle in Q16 degrees within one octant, for 0 <= b <= a and a > 0.
  function automatic longint octant_deg(longint a, longint b);
    longint x, y, z, nx, ny;
    z = 0;
    if (b == 0) return 0;
    if (b == a) return 45 * DEGQ;
    x = a * 1048576;
    y = b * 1048576;
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        nx = x + shr_trunc(y, i);
        ny = y - shr_trunc(x, i);
        z += atan_tab[i];
      end else begin
        nx = x - shr_trunc(y, i);
        ny = y + shr_trunc(x, i);
        z -= atan_tab[i];
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    if (z > 45 * DEGQ) z = 45 * DEGQ;
    return z;
  endfunction

  function automatic void stick_to_polar(input logic [10:0] cx, input logic [10:0] cy,
                                         output logic [15:0] push, output logic [8:0] deg);
    longint u, v, au, av, m, q, t, p;
    u = longint'(cy) - longint'(center_reg);
    v = longint'(center_reg) - longint'(cx);
    au = (u < 0) ? -u : u;
    av = (v < 0) ? -v : v;
    m = (au > av) ? au : av;
    if (full_scale_reg == 0) p = (m == 0) ? 0 : 65535;
    else p = (m * 100) / longint'(full_scale_reg);
    if (p > 65535) p = 65535;
    push = p[15:0];
    if (m == 0) begin
      deg = '0;
      return;
    end
    if (av <= au) q = octant_deg(au, av);
    else q = 90 * DEGQ - octant_deg(av, au);
    if (u >= 0 && v >= 0) t = q;
    else if (u < 0 && v >= 0) t = 180 * DEGQ - q;
    else if (u < 0) t = 180 * DEGQ + q;
    else t = 360 * DEGQ - q;
    t = t / DEGQ;
    if (t >= 360) t -= 360;
    deg = t[8:0];
  endfunction

  // Tracks the byte position and queues a decoded frame when one completes.
  function automatic void frame_track(rx_byte_t it);
    decoded_frame_t r;
    logic [10:0] ch0, ch1, ch2, ch3;
    logic [1:0] s1, s2;
    if (it.frame_start) rx_pos = 0;
    if (rx_pos >= FRAME_LEN) return;
    if (rx_pos < rcfd_pkg::STORE_DEPTH) rx_store[rx_pos] = it.data_byte;
    if (rx_pos != FRAME_LEN - 1) begin
      rx_pos++;
      return;
    end
    rx_pos = FRAME_LEN;
    ch0 = {rx_store[1][2:0], rx_store[0]};
    ch1 = {rx_store[2][5:0], rx_store[1][7:3]};
    ch2 = {rx_store[4][0], rx_store[3], rx_store[2][7:6]};
    ch3 = {rx_store[5][3:0], rx_store[4][7:1]};
    s1 = rx_store[5][7:6];
    s2 = rx_store[5][5:4];
    stick_to_polar(ch2, ch3, r.left_push, r.left_deg);
    stick_to_polar(ch0, ch1, r.right_push, r.right_deg);
    r.switch_code = (8'h10 << s1) | (8'h01 << s2);
    r.mouse_x = {rx_store[7], rx_store[6]};
    r.mouse_y = {rx_store[9], rx_store[8]};
    r.mouse_z = {rx_store[11], rx_store[10]};
    r.mouse_left = rx_store[12];
    r.mouse_right = rx_store[13];
    r.key_bits = rx_store[14];
    frame_exp_q.push_back(r);
  endfunction

  function automatic void field_cmp(string name, logic [15:0] e, logic [15:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, e, a);
      errors++;
    end
  endfunction

  // Both sides: predict on each accepted byte, check each accepted result.
  always @(posedge clk_i) begin
    decoded_frame_t e;
    if (rst_ni && rx_if.valid && rx_if.ready)
      frame_track('{data_byte: rx_if.data_byte, frame_start: rx_if.frame_start});
    if (rst_ni && dec_if.valid && dec_if.ready) begin
      frames_seen++;
      if (frame_exp_q.size() == 0) begin
        $display("%0t: unexpected result item, push %0d/%0d", $realtime,
                 dec_if.left_push_percent, dec_if.right_push_percent);
        errors++;
      end else begin
        e = frame_exp_q.pop_front();
        field_cmp("left_push_percent", e.left_push, dec_if.left_push_percent);
        field_cmp("left_angle_deg", 16'(e.left_deg), 16'(dec_if.left_angle_deg));
        field_cmp("right_push_percent", e.right_push, dec_if.right_push_percent);
        field_cmp("right_angle_deg", 16'(e.right_deg), 16'(dec_if.right_angle_deg));
        field_cmp("switch_code", 16'(e.switch_code), 16'(dec_if.switch_code));
        field_cmp("mouse_x", e.mouse_x, dec_if.mouse_x);
        field_cmp("mouse_y", e.mouse_y, dec_if.mouse_y);
        field_cmp("mouse_z", e.mouse_z, dec_if.mouse_z);
        field_cmp("mouse_left", 16'(e.mouse_left), 16'(dec_if.mouse_left));
        field_cmp("mouse_right", 16'(e.mouse_right), 16'(dec_if.mouse_right));
        field_cmp("key_bits", 16'(e.key_bits), 16'(dec_if.key_bits));
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Byte driver.
  int tx_gap = 0;
  always @(posedge clk_i) begin
    rx_byte_t it;
    if (rst_ni && (!rx_if.valid || rx_if.ready)) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        rx_if.valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        it = byte_q.pop_front();
        rx_if.valid <= 1'b1;
        rx_if.data_byte <= it.data_byte;
        rx_if.frame_start <= it.frame_start;
        bytes_sent++;
        tx_gap <= tx_no_gaps ? 0 : gap_len();
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver stalls, with one long hold-off on request.
  int rx_stall = 0;
  bit long_hold_done = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        rx_stall <= 400;
        dec_if.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall <= rx_stall - 1;
        dec_if.ready <= 1'b0;
      end else if (rx_no_stalls || $urandom_range(0, 2) != 0) begin
        dec_if.ready <= 1'b1;
      end else begin
        rx_stall <= gap_len();
        dec_if.ready <= 1'b0;
      end
    end
  end

  task automatic reg_write(logic idx, logic [10:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == rcfd_pkg::REG_CENTER) center_reg = val;
    else full_scale_reg = val;
  endtask

  function automatic logic [10:0] chan_pick(int kind, int off);
    int c;
    c = int'(center_reg) + off;
    if (kind == 3) return $urandom_range(0, 1) ? 11'h7FF : 11'h000;
    if (kind >= 5 || c < 0 || c > 2047) return 11'($urandom);
    return 11'(c);
  endfunction

  // Picks one stick position: centered, on an axis, on a diagonal, at the rails or anywhere.
  function automatic void stick_pick(output logic [10:0] cx, output logic [10:0] cy);
    int kind, a, sx, sy;
    kind = $urandom_range(0, 8);
    a = (kind == 4) ? $urandom_range(1, 3) : $urandom_range(1, 1023);
    sx = $urandom_range(0, 1) ? a : -a;
    sy = $urandom_range(0, 1) ? a : -a;
    case (kind)
      0: begin
        cx = chan_pick(0, 0);
        cy = chan_pick(0, 0);
      end
      1: begin
        if ($urandom_range(0, 1)) begin
          cx = chan_pick(1, sx);
          cy = chan_pick(1, 0);
        end else begin
          cx = chan_pick(1, 0);
          cy = chan_pick(1, sy);
        end
      end
      default: begin
        cx = chan_pick(kind, sx);
        cy = chan_pick(kind, sy);
      end
    endcase
  endfunction

  task automatic push_frame(bit with_start, int stop_at);
    logic [10:0] c0, c1, c2, c3;
    logic [47:0] bits;
    logic [7:0] b;
    stick_pick(c0, c1);
    stick_pick(c2, c3);
    bits = {4'($urandom), c3, c2, c1, c0};
    for (int i = 0; i < stop_at; i++) begin
      b = (i < 6) ? bits[8*i +: 8] : 8'($urandom);
      if (i >= 6 && i < 12 && $urandom_range(0, 5) == 0)
        b = $urandom_range(0, 1) ? 8'h00 : ((i % 2) ? 8'h80 : 8'hFF);
      byte_q.push_back('{data_byte: b, frame_start: (i == 0) && with_start});
    end
  endtask

  task automatic wait_idle();
    while (byte_q.size() > 0 || rx_if.valid || frame_exp_q.size() > 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  initial begin
    int phase_bytes;
    logic [10:0] cfg_c[8] = '{11'd1024, 11'd0, 11'd2047, 11'd1000, 11'd1024, 11'd0,
                              11'd512, 11'd1024};
    logic [10:0] cfg_f[8] = '{11'd660, 11'd1, 11'd1024, 11'd1, 11'd1024, 11'd1024,
                              11'd300, 11'd660};
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rx_if.valid = 1'b0;
    rx_if.data_byte = '0;
    rx_if.frame_start = 1'b0;
    dec_if.ready = 1'b0;
    center_reg = rcfd_pkg::CENTER_RST;
    full_scale_reg = rcfd_pkg::FULL_SCALE_RST;
    rx_pos = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: the first frame after reset without a start marker, then bytes
    // past the end of the frame, which must be dropped.
    for (int i = 0; i < FRAME_LEN; i++)
      byte_q.push_back('{data_byte: (i == 7 || i == 9) ? 8'h80 : (i == 6 ? 8'hFF : 8'h00),
                         frame_start: 1'b0});
    byte_q[0].data_byte = 8'h00;
    byte_q[1].data_byte = 8'h04;
    byte_q[2].data_byte = 8'h20;
    byte_q[3].data_byte = 8'h00;
    byte_q[4].data_byte = 8'h01;
    byte_q[5].data_byte = 8'hF8;
    for (int i = 0; i < 3; i++) byte_q.push_back('{data_byte: 8'hA5, frame_start: 1'b0});
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        reg_write(rcfd_pkg::REG_CENTER, ph == 4 ? 11'($urandom_range(0, 2047)) : cfg_c[ph]);
        reg_write(rcfd_pkg::REG_FULL_SCALE,
                  ph == 4 ? 11'($urandom_range(1, 1024)) : cfg_f[ph]);
      end
      tx_no_gaps = (ph == 2 || ph == 5);
      rx_no_stalls = (ph == 3);
      phase_bytes = 0;
      while (phase_bytes < 185) begin
        int kind;
        int queued;
        kind = $urandom_range(0, 19);
        queued = byte_q.size();
        if (kind == 0) begin
          // Broken frame, cut short and restarted by the next frame start.
          push_frame(1, $urandom_range(1, FRAME_LEN - 1));
        end else begin
          push_frame(1, FRAME_LEN);
          if (kind == 1)
            repeat ($urandom_range(1, 3))
              byte_q.push_back('{data_byte: 8'($urandom), frame_start: 1'b0});
        end
        phase_bytes = phase_bytes + byte_q.size() - queued;
        if (ph == 6 && !long_hold_req) long_hold_req = 1;
        while (byte_q.size() > 40) @(posedge clk_i);
      end
      wait_idle();
    end

    $display("Sent %0d frame bytes over 8 register settings; %0d decoded frames checked.",
             bytes_sent, frames_seen);
    $display("Covered centered, axis, diagonal, rail and random stick positions.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Timeout with %0d results outstanding", frame_exp_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
